[src/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define FMR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define FMR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/fmr_pkg.sv]
// Shared types, constants and helpers of the first-match replace block.
package fmr_pkg;

	localparam int PATTERN_MAX = 8;
	localparam int REPLACE_MAX = 8;
	localparam int WIN_DEPTH = 8;
	localparam int EXT_DEPTH = WIN_DEPTH + 1;
	localparam int LEN_W = 4;
	localparam int JOB_FIFO_DEPTH = 4;
	localparam int JOB_PTR_W = $clog2(JOB_FIFO_DEPTH);
	localparam int JOB_CNT_W = $clog2(JOB_FIFO_DEPTH + 1);
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_PATTERN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_TEXT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = 2'd3;

	// one item's worth of results: a bytes of win, r replacement bytes,
	// then the rest of win, n in total
	typedef struct packed {
		logic [EXT_DEPTH-1:0][7:0] win;
		logic [LEN_W-1:0]          a_cnt;
		logic [LEN_W-1:0]          r_cnt;
		logic [LEN_W-1:0]          n_cnt;
		logic                      last;
	} job_t;

	typedef struct packed {
		logic [LEN_W-1:0] held;
		logic             replaced;
	} front_stat_t;

	function automatic logic [LEN_W-1:0] clamp_pat(input logic [LEN_W-1:0] v);
		logic [LEN_W-1:0] lim;
		lim = LEN_W'(PATTERN_MAX);
		return (v > lim) ? lim : v;
	endfunction

	function automatic logic [LEN_W-1:0] clamp_rep(input logic [LEN_W-1:0] v);
		logic [LEN_W-1:0] lim;
		lim = LEN_W'(REPLACE_MAX);
		return (v > lim) ? lim : v;
	endfunction

endpackage

[src/fmr_front.sv]
// Front end: takes text items, runs the window match and builds result jobs.
module fmr_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [7:0]                  text_byte,
	input  logic                        byte_present,
	input  logic                        end_of_text,
	input  logic [63:0]                 search_pattern,
	input  logic [fmr_pkg::LEN_W-1:0]   search_length,
	input  logic [fmr_pkg::LEN_W-1:0]   replacement_length,
	input  logic                        q_full,
	output logic                        job_push,
	output fmr_pkg::job_t               job,
	output fmr_pkg::front_stat_t        stat
);
	import fmr_pkg::*;

	logic [WIN_DEPTH-1:0][7:0] win_q;
	logic [LEN_W-1:0]          held_q;
	logic                      replaced_q;

	logic [WIN_DEPTH-1:0][7:0] win_d;
	logic [LEN_W-1:0]          held_d;
	logic                      replaced_d;

	logic                      accept;
	logic [EXT_DEPTH-1:0][7:0] ext;
	logic [LEN_W-1:0]          plen;
	logic [LEN_W-1:0]          rlen;
	logic [EXT_DEPTH:0]        ok;
	logic [LEN_W-1:0]          shift;
	logic [LEN_W-1:0]          rem;
	logic [LEN_W:0]            held_p1;
	logic [LEN_W:0]            tail_len;
	logic [WIN_DEPTH-1:0][7:0] shifted;
	logic [LEN_W-1:0]          a_cnt;
	logic [LEN_W-1:0]          t_cnt;
	logic                      rep;
	logic [LEN_W:0]            total;

	assign full = q_full;
	assign accept = push && !q_full;
	assign plen = clamp_pat(search_length);
	assign rlen = clamp_rep(replacement_length);
	assign held_p1 = {1'b0, held_q} + 5'd1;

	always_comb begin
		for (int i = 0; i < WIN_DEPTH; i++) begin
			ext[i] = (held_q == LEN_W'(i)) ? text_byte : win_q[i];
		end
		ext[WIN_DEPTH] = text_byte;
	end

	// shift s is fine when what is left of the window is a pattern prefix
	always_comb begin
		for (int s = 0; s <= EXT_DEPTH; s++) begin
			tail_len = held_p1 - 5'(s);
			ok[s] = (5'(s) <= held_p1) && (tail_len <= {1'b0, plen});
			for (int i = 0; i < WIN_DEPTH; i++) begin
				if (s + i < EXT_DEPTH) begin
					if ((5'(s + i) <= {1'b0, held_q}) &&
					    (ext[s + i] != search_pattern[8*i +: 8])) begin
						ok[s] = 1'b0;
					end
				end
			end
		end
		tail_len = '0;
	end

	always_comb begin
		shift = LEN_W'(EXT_DEPTH);
		for (int s = EXT_DEPTH; s >= 0; s--) begin
			if (ok[s]) begin
				shift = LEN_W'(s);
			end
		end
	end

	assign rem = LEN_W'(held_p1 - {1'b0, shift});

	always_comb begin
		shifted = '0;
		for (int s = 0; s < EXT_DEPTH; s++) begin
			if (shift == LEN_W'(s)) begin
				for (int i = 0; i < WIN_DEPTH; i++) begin
					if (s + i < EXT_DEPTH) begin
						shifted[i] = ext[s + i];
					end
				end
			end
		end
	end

	always_comb begin
		win_d = win_q;
		held_d = held_q;
		replaced_d = replaced_q;
		a_cnt = '0;
		t_cnt = '0;
		rep = 1'b0;
		if (byte_present) begin
			if (replaced_q) begin
				a_cnt = LEN_W'(held_p1);
				held_d = '0;
			end else if (plen == '0) begin
				a_cnt = held_q;
				rep = 1'b1;
				replaced_d = 1'b1;
				win_d[0] = text_byte;
				held_d = LEN_W'(1);
				if (end_of_text) begin
					t_cnt = LEN_W'(1);
				end
			end else begin
				a_cnt = shift;
				if (rem == plen) begin
					rep = 1'b1;
					replaced_d = 1'b1;
					held_d = '0;
				end else begin
					win_d = shifted;
					held_d = rem;
					if (end_of_text) begin
						t_cnt = rem;
					end
				end
			end
		end else if (end_of_text) begin
			t_cnt = held_q;
		end
		if (end_of_text) begin
			held_d = '0;
			replaced_d = 1'b0;
		end
	end

	assign total = {1'b0, a_cnt} + {1'b0, (rep ? rlen : LEN_W'(0))} + {1'b0, t_cnt};

	always_comb begin
		job.win = ext;
		job.a_cnt = a_cnt;
		job.r_cnt = rep ? rlen : '0;
		job.n_cnt = (total > 5'(WIN_DEPTH)) ? LEN_W'(WIN_DEPTH) : LEN_W'(total);
		job.last = end_of_text;
	end

	assign job_push = accept && (end_of_text || (total != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			replaced_q <= 1'b0;
		end else if (accept) begin
			held_q <= held_d;
			replaced_q <= replaced_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			win_q <= win_d;
		end
	end

	assign stat.held = held_q;
	assign stat.replaced = replaced_q;

endmodule

[src/fmr_job_fifo.sv]
// Short job queue between the front end and the back end.
module fmr_job_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  fmr_pkg::job_t wr_job,
	output logic          q_full,
	input  logic          rd_en,
	output fmr_pkg::job_t rd_job,
	output logic          q_empty
);
	import fmr_pkg::*;

	job_t                 mem_q [JOB_FIFO_DEPTH];
	logic [JOB_PTR_W-1:0] wptr_q;
	logic [JOB_PTR_W-1:0] rptr_q;
	logic [JOB_CNT_W-1:0] cnt_q;
	logic                 do_wr;
	logic                 do_rd;

	assign q_full = (cnt_q == JOB_CNT_W'(JOB_FIFO_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr = wr_en && !q_full;
	assign do_rd = rd_en && !q_empty;
	assign rd_job = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + JOB_PTR_W'(1);
			end
			if (do_rd) begin
				rptr_q <= rptr_q + JOB_PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + JOB_CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - JOB_CNT_W'(1);
			end
		end
	end

endmodule

[src/fmr_back.sv]
// Back end: walks each job and sends its results one per cycle while pop takes them.
module fmr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  fmr_pkg::job_t job,
	input  logic          q_empty,
	output logic          q_pop,
	input  logic [63:0]   replacement_text,
	output logic          empty,
	input  logic          pop,
	output logic [7:0]    out_byte,
	output logic          out_present,
	output logic          out_last
);
	import fmr_pkg::*;

	logic [2:0]       k_q;
	logic             valid_q;
	logic [7:0]       byte_q;
	logic             present_q;
	logic             last_q;

	logic             load;
	logic             end_of_job;
	logic [LEN_W-1:0] kk;
	logic [LEN_W:0]   ar;
	logic [LEN_W-1:0] ridx;
	logic [LEN_W-1:0] widx;
	logic [7:0]       sel_byte;

	assign load = !q_empty && (!valid_q || pop);
	assign kk = {1'b0, k_q};
	assign ar = {1'b0, job.a_cnt} + {1'b0, job.r_cnt};
	assign ridx = kk - job.a_cnt;
	assign widx = kk - job.r_cnt;
	assign end_of_job = (job.n_cnt == '0) || (kk == job.n_cnt - LEN_W'(1));
	assign q_pop = load && end_of_job;

	always_comb begin
		sel_byte = '0;
		if (kk < job.a_cnt) begin
			sel_byte = job.win[k_q];
		end else if ({1'b0, kk} < ar) begin
			sel_byte = replacement_text[8*ridx[2:0] +: 8];
		end else if (widx < LEN_W'(EXT_DEPTH)) begin
			sel_byte = job.win[widx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			k_q <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				k_q <= end_of_job ? 3'd0 : k_q + 3'd1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (job.n_cnt == '0) begin
				byte_q <= '0;
				present_q <= 1'b0;
				last_q <= 1'b1;
			end else begin
				byte_q <= sel_byte;
				present_q <= 1'b1;
				last_q <= job.last && end_of_job;
			end
		end
	end

	assign empty = !valid_q;
	assign out_byte = byte_q;
	assign out_present = present_q;
	assign out_last = last_q;

endmodule

[src/first_match_replace_top.sv]
// Top level of the first-match find-and-replace block.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  text in  | push / full                | text_byte, byte_present, end_of_text
//  result   | pop / empty                | out_byte, out_present, out_last
//  config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One text item is taken per cycle while the four-entry job queue has room.
// The back end sends one result per cycle while pop takes them, so an item
// that yields n results holds it until all n are sent; the job of an item is
// written to the queue, then its first result is registered at the ports.
// Reset clears the window count, the replaced mark, the queue, the result valid flag and the config registers.
// full rises when the queue fills; a low pop only stalls the back end.
module first_match_replace_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [7:0]                     text_byte,
	input  logic                           byte_present,
	input  logic                           end_of_text,
	output logic                           empty,
	input  logic                           pop,
	output logic [7:0]                     out_byte,
	output logic                           out_present,
	output logic                           out_last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fmr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [63:0]                    cfg_data
);
	import fmr_pkg::*;
	`include "assert_macros.svh"

	logic [63:0]      search_pattern_q;
	logic [LEN_W-1:0] search_length_q;
	logic [63:0]      replacement_text_q;
	logic [LEN_W-1:0] replacement_length_q;

	logic             job_push;
	job_t             push_job;
	job_t             head_job;
	logic             q_full;
	logic             q_empty;
	logic             q_pop;
	front_stat_t      stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_pattern_q <= '0;
			search_length_q <= '0;
			replacement_text_q <= '0;
			replacement_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SEARCH_PATTERN: begin
					search_pattern_q <= cfg_data;
				end
				CFG_SEARCH_LENGTH: begin
					search_length_q <= cfg_data[LEN_W-1:0];
				end
				CFG_REPLACEMENT_TEXT: begin
					replacement_text_q <= cfg_data;
				end
				CFG_REPLACEMENT_LENGTH: begin
					replacement_length_q <= cfg_data[LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	fmr_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.push               (push),
		.full               (full),
		.text_byte          (text_byte),
		.byte_present       (byte_present),
		.end_of_text        (end_of_text),
		.search_pattern     (search_pattern_q),
		.search_length      (search_length_q),
		.replacement_length (replacement_length_q),
		.q_full             (q_full),
		.job_push           (job_push),
		.job                (push_job),
		.stat               (stat)
	);

	fmr_job_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_job  (push_job),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.rd_job  (head_job),
		.q_empty (q_empty)
	);

	fmr_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.job              (head_job),
		.q_empty          (q_empty),
		.q_pop            (q_pop),
		.replacement_text (replacement_text_q),
		.empty            (empty),
		.pop              (pop),
		.out_byte         (out_byte),
		.out_present      (out_present),
		.out_last         (out_last)
	);

	`FMR_ASSERT(a_end_clears, clk, arst_n,
		push && !full && end_of_text |=> stat.held == '0 && !stat.replaced,
		"window not cleared after end of text")
	`FMR_ASSERT(a_held_bound, clk, arst_n,
		stat.held <= LEN_W'(WIN_DEPTH),
		"held count beyond window depth")
	`FMR_ASSERT(a_blank_is_last, clk, arst_n,
		!empty && !out_present |-> out_last && out_byte == 8'd0,
		"byteless result not marked last")
	`FMR_ASSERT(a_no_push_full, clk, arst_n,
		job_push |-> !q_full,
		"job pushed into a full queue")

endmodule
